// ----- hdl/rgb_luma_laplacian_filter_unit_defines.svh -----
// Assertion macros for the luma Laplacian filter unit.
// Expects clk and arst_n in the scope of each use.
`ifndef RGB_LUMA_LAPLACIAN_FILTER_UNIT_DEFINES_SVH
`define RGB_LUMA_LAPLACIAN_FILTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rllf_pkg.sv -----
// Package for the luma Laplacian filter unit: field widths, default frame
// geometry, luma weights and the result descriptor type. No dependencies.
package rllf_pkg;

	localparam int PIXEL_W          = 24;
	localparam int COORD_W          = 6;
	localparam int LUMA_W           = 8;
	localparam int LINE_WIDTH_DEF   = 64;
	localparam int FRAME_HEIGHT_DEF = 48;

	localparam logic [7:0] COEF_R = 8'd77;
	localparam logic [7:0] COEF_G = 8'd150;
	localparam logic [7:0] COEF_B = 8'd29;
	localparam logic [LUMA_W-1:0] GRAY_MAX = 8'd255;

	// One result slot held in the emit stage.
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               lap;
	} res_t;

endpackage

// ----- hdl/rgb_luma_laplacian_filter_unit.sv -----
// Top level of the luma Laplacian filter: line memory, 3x3 window and emit stage.
// Depends on rllf_pkg and rgb_luma_laplacian_filter_unit_defines.svh.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  pixel   | pix_valid, pix_ready, pixel_rgb            | in
//  result  | res_valid, res_ready, out_col, out_row,    | out
//          | out_pixel, last_of_run                     |
//
// One pixel per cycle while the result register does not stall; a last-row pixel
// yields two results and holds the emit stage until both have been pushed.
// The line memory (one read and one write port) holds the two previous lines
// per column; read at acceptance, written back when the pixel leaves stage 1.
// Reset clears counters, valid flags and emit index; memory needs no clearing.
// A stalled result register back-pressures all stages through the ready chain.
`include "rgb_luma_laplacian_filter_unit_defines.svh"

module rgb_luma_laplacian_filter_unit #(
	parameter int LINE_WIDTH   = rllf_pkg::LINE_WIDTH_DEF,
	parameter int FRAME_HEIGHT = rllf_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [rllf_pkg::PIXEL_W-1:0] pixel_rgb,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [rllf_pkg::COORD_W-1:0] out_col,
	output logic [rllf_pkg::COORD_W-1:0] out_row,
	output logic [rllf_pkg::PIXEL_W-1:0] out_pixel,
	output logic                         last_of_run
);

	localparam int CW  = $clog2(LINE_WIDTH);
	localparam int RW  = $clog2(FRAME_HEIGHT);
	localparam int LW  = rllf_pkg::LUMA_W;
	localparam int KW  = rllf_pkg::COORD_W;
	localparam int CXW = (CW > KW) ? CW : KW;
	localparam int RXW = (RW > KW) ? RW : KW;

	// input counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// stage 1
	logic                         s1_valid;
	logic [rllf_pkg::PIXEL_W-1:0] rgb_s1;
	logic [CW-1:0]                col_s1;
	logic [RW-1:0]                row_s1;
	logic [2*LW-1:0]              rd_s1;

	// line memory: {line row-1, line row-2} per column
	logic [2*LW-1:0] lines_mem [LINE_WIDTH];

	// 3x3 window, index 0 = oldest column
	logic [LW-1:0] win_top_q [3];
	logic [LW-1:0] win_mid_q [3];
	logic [LW-1:0] win_bot_q [3];

	// stage 2 (emit)
	logic            s2_valid;
	logic [1:0]      cnt_s2;
	logic            idx_s2;
	rllf_pkg::res_t  r0_s2;
	rllf_pkg::res_t  r1_s2;

	logic pix_acc, s1_adv, s1_move, push, s2_last, s2_done;

	logic [15:0]    luma_sum;
	logic [LW-1:0]  luma_s1;
	logic           row_first, row_second, row_last;
	logic [CW-1:0]  r0_col_raw;
	logic [RW-1:0]  r0_row_raw;
	logic [CXW-1:0] r0_col_x, r1_col_x;
	logic [RXW-1:0] r0_row_x, r1_row_x;
	rllf_pkg::res_t r0_next, r1_next;
	logic [1:0]     cnt_next;

	logic [LW+2:0]  nsum;
	logic [LW+2:0]  c8;
	logic [LW+2:0]  diff;
	logic [LW-1:0]  gray;

	assign pix_acc  = pix_valid && pix_ready;
	assign push     = s2_valid && (cnt_s2 != 2'd0) && (!res_valid || res_ready);
	assign s2_last  = (cnt_s2 == 2'd1) || idx_s2;
	assign s2_done  = s2_valid && ((cnt_s2 == 2'd0) || (push && s2_last));
	assign s1_adv   = !s2_valid || s2_done;
	assign s1_move  = s1_valid && s1_adv;
	assign pix_ready = !s1_valid || s1_adv;

	// advance raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_q == CW'(LINE_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (row_q == RW'(FRAME_HEIGHT - 1)) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pix_ready) begin
			s1_valid <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			rgb_s1 <= pixel_rgb;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// line memory: read at acceptance, write back as the pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			rd_s1 <= lines_mem[col_q];
		end
		if (s1_move) begin
			lines_mem[col_s1] <= {luma_s1, rd_s1[2*LW-1:LW]};
		end
	end

	assign luma_sum = 16'(rllf_pkg::COEF_R * 16'(rgb_s1[23:16]))
		+ 16'(rllf_pkg::COEF_G * 16'(rgb_s1[15:8]))
		+ 16'(rllf_pkg::COEF_B * 16'(rgb_s1[7:0]));
	assign luma_s1 = luma_sum[15:8];

	// result schedule of the stage 1 pixel
	always_comb begin
		row_first  = (row_s1 == '0);
		row_second = (row_s1 == RW'(1));
		row_last   = (row_s1 == RW'(FRAME_HEIGHT - 1));
		if (row_first) begin
			r0_col_raw = col_s1;
			r0_row_raw = '0;
		end else begin
			r0_row_raw = row_s1 - 1'b1;
			if (col_s1 == '0) begin
				r0_col_raw = '0;
			end else if (col_s1 == CW'(1)) begin
				r0_col_raw = CW'(LINE_WIDTH - 1);
			end else begin
				r0_col_raw = col_s1 - 1'b1;
			end
		end
		r0_col_x = CXW'(r0_col_raw);
		r0_row_x = RXW'(r0_row_raw);
		r1_col_x = CXW'(col_s1);
		r1_row_x = RXW'(row_s1);
		r0_next.col = r0_col_x[KW-1:0];
		r0_next.row = r0_row_x[KW-1:0];
		r0_next.lap = !row_first && (col_s1 != '0) && (col_s1 != CW'(1));
		r1_next.col = r1_col_x[KW-1:0];
		r1_next.row = r1_row_x[KW-1:0];
		r1_next.lap = 1'b0;
		if (row_first) begin
			cnt_next = 2'd1;
		end else if (row_second) begin
			cnt_next = 2'd0;
		end else begin
			cnt_next = row_last ? 2'd2 : 2'd1;
		end
	end

	// shift window on stage 1 advance
	always_ff @(posedge clk) begin
		if (s1_move) begin
			win_top_q[0] <= win_top_q[1];
			win_top_q[1] <= win_top_q[2];
			win_top_q[2] <= rd_s1[LW-1:0];
			win_mid_q[0] <= win_mid_q[1];
			win_mid_q[1] <= win_mid_q[2];
			win_mid_q[2] <= rd_s1[2*LW-1:LW];
			win_bot_q[0] <= win_bot_q[1];
			win_bot_q[1] <= win_bot_q[2];
			win_bot_q[2] <= luma_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			idx_s2   <= 1'b0;
		end else if (s1_adv) begin
			s2_valid <= s1_valid;
			idx_s2   <= 1'b0;
		end else if (push) begin
			idx_s2 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			cnt_s2 <= cnt_next;
			r0_s2  <= r0_next;
			r1_s2  <= r1_next;
		end
	end

	// Laplacian of the current window, clamped to 0..255
	always_comb begin
		nsum = (LW+3)'(win_top_q[0]) + (LW+3)'(win_top_q[1]) + (LW+3)'(win_top_q[2])
			+ (LW+3)'(win_bot_q[0]) + (LW+3)'(win_bot_q[1]) + (LW+3)'(win_bot_q[2])
			+ (LW+3)'(win_mid_q[0]) + (LW+3)'(win_mid_q[2]);
		c8   = {win_mid_q[1], 3'b000};
		diff = c8 - nsum;
		if (nsum >= c8) begin
			gray = '0;
		end else if (diff > (LW+3)'(rllf_pkg::GRAY_MAX)) begin
			gray = rllf_pkg::GRAY_MAX;
		end else begin
			gray = diff[LW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (push) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_col     <= idx_s2 ? r1_s2.col : r0_s2.col;
			out_row     <= idx_s2 ? r1_s2.row : r0_s2.row;
			out_pixel   <= (!idx_s2 && r0_s2.lap) ? {gray, gray, gray} : '0;
			last_of_run <= s2_last;
		end
	end

	`RLLF_ASSERT_NOW(a_idx_in_range, s2_valid && idx_s2, cnt_s2 == 2'd2, "second result without two pending")
	`RLLF_ASSERT_NEXT(a_req_to_s1, pix_valid && pix_ready, s1_valid, "accepted request lost before stage 1")
	`RLLF_ASSERT_NEXT(a_win_hold, !(s1_valid && s1_adv), $stable(win_mid_q[1]) && $stable(win_bot_q[2]), "window moved without stage 1 advance")
	`RLLF_ASSERT_NOW(a_push_needs_room, push, !res_valid || res_ready, "result register overwritten")

endmodule
